// ===== rtl/frame_damage_bounding_box_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Frame damage bounding box: assertion macros
// Shorthand for clocked implication checks used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef FRAME_DAMAGE_BOUNDING_BOX_UNIT_MACROS_SVH
`define FRAME_DAMAGE_BOUNDING_BOX_UNIT_MACROS_SVH

// same-cycle implication
`define FDBB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FDBB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fdbb_pkg.sv =====
// ---------------------------------------------------------------------------
// Frame damage bounding box: package
// Frame limits, codes and the item types of the input and result channels.
// ---------------------------------------------------------------------------
package fdbb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int SIZE_W     = 11;
  localparam int PIX_W      = 24;
  localparam int FCNT_W     = 21;
  localparam int TCNT_W     = 48;

  typedef enum logic {
    OP_PIXEL   = 1'b0,
    OP_RESTART = 1'b1
  } opcode_t;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [PIX_W-1:0]   pixel_value;
  } in_item_t;

  typedef struct packed {
    logic               pixel_changed;
    logic               frame_done;
    logic               damage_found;
    logic [9:0]         box_left;
    logic [9:0]         box_top;
    logic [10:0]        box_width;
    logic [10:0]        box_height;
    logic [FCNT_W-1:0]  frame_damage_count;
    logic [TCNT_W-1:0]  total_damage_count;
    logic [TCNT_W-1:0]  total_compared_count;
    logic [TCNT_W-1:0]  comparison_count;
  } out_item_t;

endpackage

// ===== rtl/frame_damage_bounding_box_unit.sv =====
// Pixel items pass stage 1 and then the output register; restarts give no result.
// Throughput: one item per cycle while the output is not stalled; the store is
// read on accept and written as the item leaves stage 1, forwarded on a same-pixel hit.
// Reset (rst_n low, synchronous): size registers to 1024x1024, positions,
// box and counters cleared, next frame fully damaged. Store contents are
// undefined after reset and are not cleared.
// ---------------------------------------------------------------------------
// Frame damage bounding box unit
// Compares each pixel with the stored previous frame, tracks the damage
// box and counters, and reports a frame summary on the last pixel.
// ---------------------------------------------------------------------------
`include "frame_damage_bounding_box_unit_macros.svh"

module frame_damage_bounding_box_unit
  import fdbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  cfg_index_t        cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item
);

  typedef struct packed {
    opcode_t          opcode;
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             done;
  } s1_t;

  logic [PIX_W-1:0]  mem [1 << ADDR_W];

  logic [SIZE_W-1:0] frame_width_r, frame_height_r;
  logic [COL_W-1:0]  col_pos_r, col_pos_nxt;
  logic [ROW_W-1:0]  row_pos_r, row_pos_nxt;

  s1_t               s1_r, s1_nxt;
  logic              s1_valid_r;
  logic [PIX_W-1:0]  rd_data_r;
  logic              fwd_hit_r;
  logic [PIX_W-1:0]  fwd_pix_r;

  logic              first_r, first_nxt;
  logic [COL_W-1:0]  min_col_r, min_col_nxt, max_col_r, max_col_nxt;
  logic [ROW_W-1:0]  min_row_r, min_row_nxt, max_row_r, max_row_nxt;
  logic [FCNT_W-1:0] fcnt_r, fcnt_nxt;
  logic [TCNT_W-1:0] tdmg_r, tdmg_nxt, tcmp_r, tcmp_nxt, ccnt_r, ccnt_nxt;

  out_item_t         out_r, out_nxt;
  logic              out_valid_r;

  logic              in_acc, s1_adv, out_free;
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              last_col, last_row;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  prev_pix;
  logic              changed;

  // ---- stage 0: position and store read ----
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = SIZE_W'(1);
    end else if (frame_width_r > SIZE_W'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width_r;
    end
    if (frame_height_r == '0) begin
      h_eff = SIZE_W'(1);
    end else if (frame_height_r > SIZE_W'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height_r;
    end
  end

  assign col = (SIZE_W'(col_pos_r) < w_eff) ? col_pos_r : COL_W'(w_eff - SIZE_W'(1));
  assign row = (SIZE_W'(row_pos_r) < h_eff) ? row_pos_r : ROW_W'(h_eff - SIZE_W'(1));
  assign last_col = SIZE_W'(col) >= (w_eff - SIZE_W'(1));
  assign last_row = SIZE_W'(row) >= (h_eff - SIZE_W'(1));
  assign rd_addr  = {row, col};

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && ((s1_r.opcode == OP_RESTART) || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    col_pos_nxt   = col_pos_r;
    row_pos_nxt   = row_pos_r;
    s1_nxt.opcode = in_item.opcode;
    s1_nxt.pix    = in_item.pixel_value;
    s1_nxt.col    = col;
    s1_nxt.row    = row;
    s1_nxt.done   = last_col && last_row;
    if (in_acc) begin
      if (in_item.opcode == OP_RESTART || (last_col && last_row)) begin
        col_pos_nxt = '0;
        row_pos_nxt = '0;
      end else if (last_col) begin
        col_pos_nxt = '0;
        row_pos_nxt = row + ROW_W'(1);
      end else begin
        col_pos_nxt = col + COL_W'(1);
        row_pos_nxt = row;
      end
    end
  end

  // ---- stage 1: compare, update statistics, write back ----
  assign prev_pix = fwd_hit_r ? fwd_pix_r : rd_data_r;
  assign changed  = first_r || (prev_pix != s1_r.pix);

  always_comb begin
    first_nxt   = first_r;
    min_col_nxt = min_col_r;
    max_col_nxt = max_col_r;
    min_row_nxt = min_row_r;
    max_row_nxt = max_row_r;
    fcnt_nxt    = fcnt_r;
    tdmg_nxt    = tdmg_r;
    tcmp_nxt    = tcmp_r;
    ccnt_nxt    = ccnt_r;
    out_nxt     = '0;
    if (s1_adv) begin
      if (s1_r.opcode == OP_RESTART) begin
        first_nxt   = 1'b1;
        min_col_nxt = '0;
        max_col_nxt = '0;
        min_row_nxt = '0;
        max_row_nxt = '0;
        fcnt_nxt    = '0;
        tdmg_nxt    = '0;
        tcmp_nxt    = '0;
        ccnt_nxt    = '0;
      end else begin
        tcmp_nxt = tcmp_r + TCNT_W'(1);
        if (!first_r) begin
          ccnt_nxt = ccnt_r + TCNT_W'(1);
        end
        if (changed) begin
          if (fcnt_r == '0) begin
            min_col_nxt = s1_r.col;
            max_col_nxt = s1_r.col;
            min_row_nxt = s1_r.row;
            max_row_nxt = s1_r.row;
          end else begin
            if (s1_r.col < min_col_r) min_col_nxt = s1_r.col;
            if (s1_r.col > max_col_r) max_col_nxt = s1_r.col;
            if (s1_r.row < min_row_r) min_row_nxt = s1_r.row;
            if (s1_r.row > max_row_r) max_row_nxt = s1_r.row;
          end
          fcnt_nxt = fcnt_r + FCNT_W'(1);
          tdmg_nxt = tdmg_r + TCNT_W'(1);
        end
        out_nxt.pixel_changed = changed;
        if (s1_r.done) begin
          out_nxt.frame_done = 1'b1;
          if (fcnt_nxt != '0) begin
            out_nxt.damage_found = 1'b1;
            out_nxt.box_left     = min_col_nxt;
            out_nxt.box_top      = min_row_nxt;
            out_nxt.box_width    = SIZE_W'(max_col_nxt) - SIZE_W'(min_col_nxt) + SIZE_W'(1);
            out_nxt.box_height   = SIZE_W'(max_row_nxt) - SIZE_W'(min_row_nxt) + SIZE_W'(1);
          end
          out_nxt.frame_damage_count   = fcnt_nxt;
          out_nxt.total_damage_count   = tdmg_nxt;
          out_nxt.total_compared_count = tcmp_nxt;
          out_nxt.comparison_count     = ccnt_nxt;
          first_nxt   = 1'b0;
          min_col_nxt = '0;
          max_col_nxt = '0;
          min_row_nxt = '0;
          max_row_nxt = '0;
          fcnt_nxt    = '0;
        end
      end
    end
  end

  // ---- previous-frame store ----
  always_ff @(posedge clk) begin
    if (s1_adv && s1_r.opcode == OP_PIXEL) begin
      mem[{s1_r.row, s1_r.col}] <= s1_r.pix;
    end
    if (in_acc) begin
      rd_data_r <= mem[rd_addr];
      s1_r      <= s1_nxt;
      // write from the item leaving stage 1 lands this edge; forward it
      fwd_hit_r <= s1_valid_r && (s1_r.opcode == OP_PIXEL) &&
                   ({s1_r.row, s1_r.col} == rd_addr);
      fwd_pix_r <= s1_r.pix;
    end
    if (s1_adv && s1_r.opcode == OP_PIXEL) begin
      out_r <= out_nxt;
    end
  end

  // ---- control and statistics ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= SIZE_W'(MAX_WIDTH);
      frame_height_r <= SIZE_W'(MAX_HEIGHT);
      col_pos_r      <= '0;
      row_pos_r      <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      first_r        <= 1'b1;
      min_col_r      <= '0;
      max_col_r      <= '0;
      min_row_r      <= '0;
      max_row_r      <= '0;
      fcnt_r         <= '0;
      tdmg_r         <= '0;
      tcmp_r         <= '0;
      ccnt_r         <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
          CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
          default: ;
        endcase
      end
      col_pos_r  <= col_pos_nxt;
      row_pos_r  <= row_pos_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv && s1_r.opcode == OP_PIXEL) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      first_r   <= first_nxt;
      min_col_r <= min_col_nxt;
      max_col_r <= max_col_nxt;
      min_row_r <= min_row_nxt;
      max_row_r <= max_row_nxt;
      fcnt_r    <= fcnt_nxt;
      tdmg_r    <= tdmg_nxt;
      tcmp_r    <= tcmp_nxt;
      ccnt_r    <= ccnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // ---- assertions ----
  `FDBB_ASSERT_IMP(a_stall_needs_s1, clk, rst_n, in_stall, s1_valid_r && out_valid_r,
    "input stalled without a blocked item in stage 1")
  `FDBB_ASSERT_IMP(a_no_box_without_damage, clk, rst_n,
    out_valid && !out_item.damage_found,
    out_item.box_width == '0 && out_item.box_height == '0,
    "box reported without damage")
  `FDBB_ASSERT_IMP(a_damage_has_count, clk, rst_n,
    out_valid && out_item.damage_found,
    out_item.frame_done && out_item.frame_damage_count != '0,
    "damage flag without frame damage count")
  `FDBB_ASSERT_NXT(a_restart_arms_first, clk, rst_n,
    s1_adv && s1_r.opcode == OP_RESTART,
    first_r && fcnt_r == '0 && tcmp_r == '0,
    "restart did not clear statistics")

endmodule
